// ===== design/ztr_pkg.sv =====
// Package for the z-buffered triangle rasterizer.
// Shared types and constants; no dependencies.
package ztr_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_EDGE,
        S_DIV,
        S_MEM,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load_tri;
        logic calc_edge;
        logic div_start;
        logic mem_rd;
        logic commit;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic clearing;
        logic in_tri;
        logic div_done;
        logic walking;
    } t_status;

    localparam logic [0:0] MODE_LOAD = 1'b0;
    localparam logic [0:0] REG_WIDTH = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

endpackage

// ===== design/ztr_if.sv =====
// Valid/ready channel interface for the rasterizer.
// Depends on nothing; payload width set per instance.
interface ztr_if #(
    parameter int W = 8
) (
    input logic i_clk
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/ztr_ctrl.sv =====
// Sequencer for the rasterizer: loads, pixel steps and output handoff.
// Depends on ztr_pkg.
module ztr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_mode,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  ztr_pkg::t_status  i_status,
    output ztr_pkg::t_cmd     o_cmd
);
    ztr_pkg::t_state r_state, n_state;
    logic            r_is_load, n_is_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ztr_pkg::S_IDLE;
            r_is_load <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_is_load <= n_is_load;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_is_load = r_is_load;
        case (r_state)
            ztr_pkg::S_IDLE: begin
                if (i_in_valid && !i_status.clearing) begin
                    n_is_load = (i_mode == ztr_pkg::MODE_LOAD);
                    if (i_mode == ztr_pkg::MODE_LOAD) n_state = ztr_pkg::S_LOAD;
                    else if (i_status.walking) n_state = ztr_pkg::S_EDGE;
                    else n_state = ztr_pkg::S_OUT;
                end
            end
            ztr_pkg::S_LOAD: n_state = ztr_pkg::S_OUT;
            ztr_pkg::S_EDGE: n_state = i_status.in_tri ? ztr_pkg::S_DIV : ztr_pkg::S_OUT;
            ztr_pkg::S_DIV: if (i_status.div_done) n_state = ztr_pkg::S_MEM;
            ztr_pkg::S_MEM: n_state = ztr_pkg::S_OUT;
            ztr_pkg::S_OUT: if (i_out_ready) n_state = ztr_pkg::S_IDLE;
            default: n_state = ztr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ztr_pkg::S_IDLE: o_in_ready = !i_status.clearing;
            ztr_pkg::S_LOAD: o_cmd.load_tri = 1'b1;
            ztr_pkg::S_EDGE: begin
                o_cmd.calc_edge = 1'b1;
                o_cmd.div_start = i_status.in_tri;
                o_cmd.advance   = !i_status.in_tri;
            end
            ztr_pkg::S_DIV: o_cmd.mem_rd = i_status.div_done;
            ztr_pkg::S_MEM: begin
                o_cmd.commit  = 1'b1;
                o_cmd.advance = 1'b1;
            end
            ztr_pkg::S_OUT: o_out_valid = 1'b1;
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ztr_pkg::S_IDLE) |-> !o_in_ready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid) else $error("result dropped");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load_tri, o_cmd.calc_edge, o_cmd.mem_rd, o_cmd.commit}))
        else $error("command clash");
`endif
endmodule

// ===== design/ztr_datapath.sv =====
// Rasterizer datapath: triangle setup, edge terms, serial divider, depth store.
// Depends on ztr_pkg.
module ztr_datapath #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int COORD_BITS = 12,
    parameter int DEPTH_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ztr_pkg::t_cmd                i_cmd,
    output ztr_pkg::t_status             o_status,
    input  logic                         i_start,
    input  logic                         i_mode,
    input  logic signed [COORD_BITS-1:0] i_ax, i_ay, i_bx, i_by, i_cx, i_cy,
    input  logic signed [DEPTH_BITS-1:0] i_az, i_bz, i_cz,
    input  logic [31:0]                  i_color,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [8:0]                   i_cfg_data,
    output logic                         o_write_valid,
    output logic [7:0]                   o_pixel_x,
    output logic [7:0]                   o_pixel_y,
    output logic [31:0]                  o_pixel_color,
    output logic signed [DEPTH_BITS-1:0] o_pixel_depth,
    output logic                         o_walk_done
);
    localparam int XB = $clog2(MAX_WIDTH);
    localparam int YB = $clog2(MAX_HEIGHT);
    localparam int DB = COORD_BITS + 2;          // coordinate difference
    localparam int AB = 2 * DB + 1;              // cross product
    localparam int NB = DEPTH_BITS + AB + 2;     // weighted depth sum
    localparam int CB = $clog2(NB + 1);
    localparam int SB = XB + YB;

    logic [8:0] r_img_w, r_img_h;
    logic signed [COORD_BITS-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic signed [DEPTH_BITS-1:0] r_az, r_bz, r_cz;
    logic signed [COORD_BITS-1:0] r_lax, r_lay, r_lbx, r_lby, r_lcx, r_lcy;
    logic [31:0] r_color, r_lcolor;
    logic signed [AB-1:0] r_area;
    logic [XB-1:0] r_x0, r_x1, r_cur_x;
    logic [YB-1:0] r_y0, r_y1, r_cur_y;
    logic r_walking;

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_lax <= i_ax; r_lay <= i_ay; r_lbx <= i_bx;
            r_lby <= i_by; r_lcx <= i_cx; r_lcy <= i_cy;
            if (i_mode == ztr_pkg::MODE_LOAD) begin
                r_az <= i_az; r_bz <= i_bz; r_cz <= i_cz;
            end
            r_lcolor <= i_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= 9'd256;
            r_img_h <= 9'd256;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == ztr_pkg::REG_WIDTH) r_img_w <= i_cfg_data;
            else r_img_h <= i_cfg_data;
        end
    end

    // setup
    logic signed [DB-1:0] s_bax, s_bay, s_cax, s_cay;
    logic signed [AB-1:0] s_area;
    logic signed [DB-1:0] s_minx, s_maxx, s_miny, s_maxy, s_wl, s_hl;
    logic [12:0] s_w, s_h;

    always_comb begin
        s_bax = DB'(r_lbx) - DB'(r_lax);
        s_bay = DB'(r_lby) - DB'(r_lay);
        s_cax = DB'(r_lcx) - DB'(r_lax);
        s_cay = DB'(r_lcy) - DB'(r_lay);
        s_area = AB'(s_cay) * AB'(s_bax) - AB'(s_bay) * AB'(s_cax);
        s_minx = DB'(r_lax);
        if (DB'(r_lbx) < s_minx) s_minx = DB'(r_lbx);
        if (DB'(r_lcx) < s_minx) s_minx = DB'(r_lcx);
        s_maxx = DB'(r_lax);
        if (DB'(r_lbx) > s_maxx) s_maxx = DB'(r_lbx);
        if (DB'(r_lcx) > s_maxx) s_maxx = DB'(r_lcx);
        s_miny = DB'(r_lay);
        if (DB'(r_lby) < s_miny) s_miny = DB'(r_lby);
        if (DB'(r_lcy) < s_miny) s_miny = DB'(r_lcy);
        s_maxy = DB'(r_lay);
        if (DB'(r_lby) > s_maxy) s_maxy = DB'(r_lby);
        if (DB'(r_lcy) > s_maxy) s_maxy = DB'(r_lcy);
        s_w = (r_img_w == '0) ? 13'd1 : 13'(r_img_w);
        if (s_w > 13'(MAX_WIDTH)) s_w = 13'(MAX_WIDTH);
        s_h = (r_img_h == '0) ? 13'd1 : 13'(r_img_h);
        if (s_h > 13'(MAX_HEIGHT)) s_h = 13'(MAX_HEIGHT);
        s_wl = DB'(s_w) - DB'(1);
        s_hl = DB'(s_h) - DB'(1);
        if (s_minx < 0) s_minx = '0;
        if (s_miny < 0) s_miny = '0;
        if (s_maxx > s_wl) s_maxx = s_wl;
        if (s_maxy > s_hl) s_maxy = s_hl;
    end

    logic s_empty;
    assign s_empty = (s_area == '0) || (s_minx > s_maxx) || (s_miny > s_maxy);

    // edge terms for the current pixel
    logic signed [DB-1:0] e_apx, e_apy, e_bax, e_bay, e_cax, e_cay;
    logic signed [AB-1:0] e_ux, e_uy, e_uz, e_w0;
    logic e_inside;
    always_comb begin
        e_apx = DB'(r_ax) - DB'($signed({1'b0, r_cur_x}));
        e_apy = DB'(r_ay) - DB'($signed({1'b0, r_cur_y}));
        e_bax = DB'(r_bx) - DB'(r_ax);
        e_bay = DB'(r_by) - DB'(r_ay);
        e_cax = DB'(r_cx) - DB'(r_ax);
        e_cay = DB'(r_cy) - DB'(r_ay);
        e_ux = AB'(e_bay) * AB'(e_apx) - AB'(e_apy) * AB'(e_bax);
        e_uy = AB'(e_apy) * AB'(e_cax) - AB'(e_cay) * AB'(e_apx);
        e_uz = r_area;
        if (r_area < 0) begin
            e_ux = -e_ux; e_uy = -e_uy; e_uz = -e_uz;
        end
        e_w0 = e_uz - e_ux - e_uy;
        e_inside = (e_ux >= 0) && (e_uy >= 0) && (e_w0 >= 0);
    end

    // registered weights and products
    logic signed [AB-1:0] r_w0, r_wu, r_wv, r_uz;
    logic signed [NB-1:0] r_num;
    logic [1:0] r_mstep;
    logic r_dbusy;
    logic [NB-1:0] r_q, r_rem;
    logic [CB-1:0] r_cnt;
    logic r_neg, r_ddone;
    logic [NB-1:0] d_abs, d_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_ddone <= 1'b0;
        end else begin
            r_ddone <= r_dbusy && !i_cmd.div_start && (r_mstep == 2'd3) && (r_cnt == '0);
            if (i_cmd.div_start) begin
                r_w0 <= e_w0; r_wu <= e_uy; r_wv <= e_ux; r_uz <= e_uz;
                r_num <= '0;
                r_mstep <= '0;
                r_dbusy <= 1'b1;
            end else if (r_dbusy) begin
                // one multiply-accumulate per cycle, then serial divide
                if (r_mstep == 2'd0) begin
                    r_num <= r_num + NB'(r_az) * NB'(r_w0);
                    r_mstep <= 2'd1;
                end else if (r_mstep == 2'd1) begin
                    r_num <= r_num + NB'(r_bz) * NB'(r_wu);
                    r_mstep <= 2'd2;
                end else if (r_mstep == 2'd2) begin
                    r_num <= r_num + NB'(r_cz) * NB'(r_wv);
                    r_mstep <= 2'd3;
                    r_cnt <= CB'(NB);
                end else begin
                    if (r_cnt == CB'(NB)) begin
                        r_neg <= r_num[NB-1];
                        r_q <= d_abs;
                        r_rem <= '0;
                        r_cnt <= r_cnt - 1'b1;
                    end else begin
                        if (d_trial >= NB'(r_uz)) begin
                            r_rem <= d_trial - NB'(r_uz);
                            r_q <= {r_q[NB-2:0], 1'b1};
                        end else begin
                            r_rem <= d_trial;
                            r_q <= {r_q[NB-2:0], 1'b0};
                        end
                        if (r_cnt == '0) r_dbusy <= 1'b0;
                        else r_cnt <= r_cnt - 1'b1;
                    end
                end
            end
        end
    end
    assign d_abs = r_num[NB-1] ? NB'(-r_num) : NB'(r_num);
    assign d_trial = {r_rem[NB-2:0], r_q[NB-1]};

    logic signed [DEPTH_BITS-1:0] z_val;
    assign z_val = r_neg ? DEPTH_BITS'(-r_q) : DEPTH_BITS'(r_q);

    // depth store: cleared by a sweep after reset
    logic [DEPTH_BITS-1:0] depth_mem [0:(1<<SB)-1];
    logic [SB-1:0] r_clr_addr;
    logic r_clearing;
    logic [DEPTH_BITS-1:0] r_rd;
    logic [SB-1:0] m_addr;
    assign m_addr = {r_cur_y, r_cur_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == '1) r_clearing <= 1'b0;
        end
    end

    logic m_win;
    assign m_win = $signed(z_val) > $signed(r_rd);

    always_ff @(posedge i_clk) begin
        if (r_clearing) depth_mem[r_clr_addr] <= {1'b1, {(DEPTH_BITS-1){1'b0}}};
        else if (i_cmd.commit && m_win) depth_mem[m_addr] <= z_val;
        if (i_cmd.mem_rd) r_rd <= depth_mem[m_addr];
    end

    // walk state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walking <= 1'b0;
            r_ax <= '0; r_ay <= '0; r_bx <= '0; r_by <= '0; r_cx <= '0; r_cy <= '0;
            r_area <= '0; r_color <= '0;
            r_x0 <= '0; r_x1 <= '0; r_y0 <= '0; r_y1 <= '0;
            r_cur_x <= '0; r_cur_y <= '0;
            o_write_valid <= 1'b0; o_walk_done <= 1'b1;
            o_pixel_x <= '0; o_pixel_y <= '0; o_pixel_color <= '0; o_pixel_depth <= '0;
        end else begin
            if (i_start) begin
                o_write_valid <= 1'b0; o_walk_done <= 1'b1;
                o_pixel_x <= '0; o_pixel_y <= '0; o_pixel_color <= '0; o_pixel_depth <= '0;
            end
            if (i_cmd.load_tri) begin
                r_ax <= r_lax; r_ay <= r_lay; r_bx <= r_lbx;
                r_by <= r_lby; r_cx <= r_lcx; r_cy <= r_lcy;
                r_area <= s_area; r_color <= r_lcolor;
                r_walking <= !s_empty;
                o_walk_done <= s_empty;
                if (!s_empty) begin
                    r_x0 <= XB'(s_minx); r_x1 <= XB'(s_maxx);
                    r_y0 <= YB'(s_miny); r_y1 <= YB'(s_maxy);
                    r_cur_x <= XB'(s_minx); r_cur_y <= YB'(s_miny);
                end
            end
            if (i_cmd.commit && m_win) begin
                o_write_valid <= 1'b1;
                o_pixel_x <= 8'(r_cur_x); o_pixel_y <= 8'(r_cur_y);
                o_pixel_color <= r_color; o_pixel_depth <= z_val;
            end
            if (i_cmd.advance) begin
                if (r_cur_y < r_y1) begin
                    r_cur_y <= r_cur_y + 1'b1;
                    o_walk_done <= 1'b0;
                end else if (r_cur_x < r_x1) begin
                    r_cur_y <= r_y0;
                    r_cur_x <= r_cur_x + 1'b1;
                    o_walk_done <= 1'b0;
                end else begin
                    r_walking <= 1'b0;
                    o_walk_done <= 1'b1;
                end
            end else if (i_cmd.calc_edge) begin
                o_walk_done <= 1'b0;
            end
        end
    end

    assign o_status.clearing = r_clearing;
    assign o_status.in_tri   = e_inside;
    assign o_status.div_done = r_ddone;
    assign o_status.walking  = r_walking;

`ifndef NO_ASSERTIONS
    a_cursor_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_walking |-> (r_cur_x >= r_x0 && r_cur_x <= r_x1)) else $error("cursor x out");
    a_cursor_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_walking |-> (r_cur_y >= r_y0 && r_cur_y <= r_y1)) else $error("cursor y out");
    a_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_walking |-> (r_area != '0)) else $error("walk on degenerate triangle");
`endif
endmodule

// ===== design/zbuffer_triangle_rasterizer.sv =====
// Top level of the z-buffered triangle rasterizer.
// Depends on ztr_pkg, ztr_if, ztr_ctrl and ztr_datapath.
//
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid/ready   | mode, vertices, depths, fill_color
//  out_ch  | out | valid/ready   | write_valid, pixel, color, depth, walk_done
//  cfg     | in  | write enable  | index, 9-bit data
//
// A load passes through the load state and then the output handoff; an inside
// pixel goes through the edge, divide and memory states, set by the one-bit-per-cycle
// divider over NB = DEPTH_BITS + 2*COORD_BITS + 7 bits; an outside pixel goes from
// the edge state to output. After reset the depth store is swept; the input is held off
// until it ends. One item is in work at a time; a stalled result holds the input side.
module zbuffer_triangle_rasterizer #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int COORD_BITS = 12,
    parameter int DEPTH_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ztr_if.sink         in_ch,
    ztr_if.source       out_ch,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [8:0]  i_cfg_data
);
    localparam int CB = COORD_BITS;
    localparam int DB = DEPTH_BITS;

    ztr_pkg::t_cmd    w_cmd;
    ztr_pkg::t_status w_status;
    logic w_accept;
    assign w_accept = in_ch.valid && in_ch.ready;

    ztr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .i_mode     (in_ch.data[0]),
        .o_in_ready (in_ch.ready),
        .i_out_ready(out_ch.ready),
        .o_out_valid(out_ch.valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    logic               wv, wd;
    logic [7:0]         px, py;
    logic [31:0]        pc;
    logic signed [DB-1:0] pd;

    ztr_datapath #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
        .COORD_BITS(COORD_BITS), .DEPTH_BITS(DEPTH_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd), .o_status(w_status),
        .i_start(w_accept), .i_mode(in_ch.data[0]),
        .i_ax(in_ch.data[CB:1]),
        .i_ay(in_ch.data[2*CB:CB+1]),
        .i_az(in_ch.data[2*CB+DB:2*CB+1]),
        .i_bx(in_ch.data[3*CB+DB:2*CB+DB+1]),
        .i_by(in_ch.data[4*CB+DB:3*CB+DB+1]),
        .i_bz(in_ch.data[4*CB+2*DB:4*CB+DB+1]),
        .i_cx(in_ch.data[5*CB+2*DB:4*CB+2*DB+1]),
        .i_cy(in_ch.data[6*CB+2*DB:5*CB+2*DB+1]),
        .i_cz(in_ch.data[6*CB+3*DB:6*CB+2*DB+1]),
        .i_color(in_ch.data[6*CB+3*DB+32:6*CB+3*DB+1]),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_write_valid(wv), .o_pixel_x(px), .o_pixel_y(py),
        .o_pixel_color(pc), .o_pixel_depth(pd), .o_walk_done(wd)
    );

    assign out_ch.data = {wd, pd, pc, py, px, wv};
endmodule
